FILE: rtl/h264_annexb_frame_splitter_unit_macros.svh
// ----------------------------------------------------------------------------
// H.264 Annex B frame splitter - assertion macros
// Shared concurrent assertion shorthands for the splitter checkers.
// ----------------------------------------------------------------------------
`ifndef H264_ANNEXB_FRAME_SPLITTER_UNIT_MACROS_SVH
`define H264_ANNEXB_FRAME_SPLITTER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define AHFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define AHFS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ahfs_pkg.sv
// ----------------------------------------------------------------------------
// ahfs_pkg
// Types, constants and start code detection for the Annex B frame splitter.
// ----------------------------------------------------------------------------
package ahfs_pkg;

    localparam int C_WIN_DEPTH     = 7;
    localparam int C_NUM_CELLS     = C_WIN_DEPTH - 1;
    localparam int C_MIN_FRAME_GAP = 4;

    localparam logic [4:0] C_NAL_TYPE_MASK  = 5'h1F;
    localparam logic [4:0] C_NAL_TYPE_SPS   = 5'h07;
    localparam logic [4:0] C_NAL_TYPE_SLICE = 5'h01;
    localparam int         C_FIRST_MB_BIT   = 7;

    typedef struct packed {
        logic       vld;
        logic [7:0] data;
    } t_cell;

    typedef logic [5:0][7:0] t_span;

    function automatic logic f_boundary(input t_span b);
        logic [7:0] hdr;
        logic [7:0] nxt;
        logic       hit;
        hit = 1'b1;
        hdr = b[3];
        nxt = b[4];
        if (b[0] == 8'h00 && b[1] == 8'h00 && b[2] == 8'h01) begin
            hdr = b[3];
            nxt = b[4];
        end else if (b[0] == 8'h00 && b[1] == 8'h00 && b[2] == 8'h00 && b[3] == 8'h01) begin
            hdr = b[4];
            nxt = b[5];
        end else begin
            hit = 1'b0;
        end
        f_boundary = hit &&
            (((hdr[4:0] & C_NAL_TYPE_MASK) == C_NAL_TYPE_SPS) ||
             (((hdr[4:0] & C_NAL_TYPE_MASK) == C_NAL_TYPE_SLICE) && nxt[C_FIRST_MB_BIT]));
    endfunction

endpackage

FILE: rtl/h264_annexb_frame_splitter_unit.sv
// A byte's word is registered when the byte that completes its 7-byte window
// is accepted; an abort word is registered at stream end if a frame is open.
// Throughput: one byte per cycle unless stalled; six slots shift per byte.
// Input stall follows the output register: high only while a word waits.
// Reset (synchronous, active low) empties the window and closes any frame.
// ----------------------------------------------------------------------------
// h264_annexb_frame_splitter_unit
// Cuts an Annex B byte stream into frames at SPS or first-slice start codes.
// ----------------------------------------------------------------------------
module h264_annexb_frame_splitter_unit
    import ahfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_stream_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_frame_end,
    output logic       o_frame_abort
);

    t_cell                    cells [C_NUM_CELLS];
    t_cell                    nexts [C_NUM_CELLS];
    logic [C_WIN_DEPTH-1:0][7:0] win;
    t_span                    span0;
    t_span                    span1;

    logic       acc;
    logic       shift;
    logic       clear;
    logic       full;
    logic       bnd0;
    logic       bnd1;
    logic       open;
    logic [2:0] bss_eff;
    logic [3:0] next_off;
    logic       ends;

    logic       r_in_frame;
    logic       n_in_frame;
    logic [2:0] r_bss;
    logic [2:0] n_bss;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       load;
    logic [7:0] n_out_byte;
    logic       n_frame_end;
    logic       n_frame_abort;
    logic [7:0] r_out_byte;
    logic       r_frame_end;
    logic       r_frame_abort;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign acc        = i_in_valid & ~o_in_stall;
    assign shift      = acc & ~i_stream_end;
    assign clear      = acc & i_stream_end;

    genvar g;
    generate
        for (g = 0; g < C_NUM_CELLS; g++) begin : g_cell
            if (g == C_NUM_CELLS - 1) begin : g_tail
                assign nexts[g].vld  = 1'b1;
                assign nexts[g].data = i_data_byte;
            end else begin : g_mid
                assign nexts[g] = cells[g+1];
            end
            ahfs_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_clear (clear),
                .i_next  (nexts[g]),
                .o_cell  (cells[g])
            );
            assign win[g] = cells[g].data;
        end
    endgenerate

    assign win[C_WIN_DEPTH-1] = i_data_byte;
    assign full               = cells[0].vld;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            span0[k] = win[k];
            span1[k] = win[k+1];
        end
    end

    assign bnd0     = f_boundary(span0);
    assign bnd1     = f_boundary(span1);
    assign open     = r_in_frame | bnd0;
    assign bss_eff  = r_in_frame ? r_bss : 3'd0;
    assign next_off = {1'b0, bss_eff} + 4'd1;
    assign ends     = (next_off >= 4'(C_MIN_FRAME_GAP)) && bnd1;

    always_comb begin
        n_in_frame    = r_in_frame;
        n_bss         = r_bss;
        load          = 1'b0;
        n_out_byte    = win[0];
        n_frame_end   = ends;
        n_frame_abort = 1'b0;
        if (clear) begin
            n_in_frame    = 1'b0;
            n_bss         = 3'd0;
            load          = r_in_frame;
            n_out_byte    = 8'h00;
            n_frame_end   = 1'b0;
            n_frame_abort = 1'b1;
        end else if (shift && full && open) begin
            load       = 1'b1;
            n_in_frame = ~ends;
            if (ends) begin
                n_bss = 3'd0;
            end else begin
                n_bss = next_off[3] ? 3'd7 : next_off[2:0];
            end
        end
    end

    always_comb begin
        priority if (load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_bss       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_frame  <= n_in_frame;
            r_bss       <= n_bss;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte    <= n_out_byte;
            r_frame_end   <= n_frame_end;
            r_frame_abort <= n_frame_abort;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_frame_end   = r_frame_end;
    assign o_frame_abort = r_frame_abort;

endmodule

FILE: rtl/ahfs_cell.sv
// ----------------------------------------------------------------------------
// ahfs_cell
// One lookahead window slot: holds a byte and its valid bit, loads its
// neighbor's slot on shift, empties on clear.
// ----------------------------------------------------------------------------
module ahfs_cell
    import ahfs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  logic  i_clear,
    input  t_cell i_next,
    output t_cell o_cell
);

    logic       r_vld;
    logic       n_vld;
    logic [7:0] r_data;

    always_comb begin
        priority if (i_clear) begin
            n_vld = 1'b0;
        end else if (i_shift) begin
            n_vld = i_next.vld;
        end else begin
            n_vld = r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_next.data;
        end
    end

    assign o_cell.vld  = r_vld;
    assign o_cell.data = r_data;

endmodule

FILE: rtl/ahfs_checker.sv
// ----------------------------------------------------------------------------
// ahfs_checker
// Port-level checks for the Annex B frame splitter, bound to the top level.
// ----------------------------------------------------------------------------
`include "h264_annexb_frame_splitter_unit_macros.svh"

module ahfs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [7:0] i_data_byte,
    input logic       i_stream_end,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_frame_end,
    input logic       o_frame_abort
);

    `AHFS_ASSERT_IMP(a_abort_word, i_clk, i_rst_n, o_out_valid && o_frame_abort, o_out_byte == 8'h00 && !o_frame_end, "abort word carries data or end mark")
    `AHFS_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid, "input stalled with no word waiting")
    `AHFS_ASSERT_NXT(a_end_no_data, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_stream_end, !(o_out_valid && !o_frame_abort && !$past(o_out_valid && i_out_stall)), "data word produced by stream end")
    `AHFS_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_byte) && $stable(o_frame_end) && $stable(o_frame_abort), "stalled word changed")

endmodule

bind h264_annexb_frame_splitter_unit ahfs_checker u_ahfs_checker (.*);
